// ----- hdl/rnpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Radius neighbor pair finder package
// Shared widths and the controller state type.
// ----------------------------------------------------------------------------
package rnpf_pkg;

    localparam int COORD_W = 16;
    localparam int IDX_W   = 6;
    localparam int POS_W   = 3 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int R2_W    = 2 * (COORD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE,
        S_OVF
    } state_t;

endpackage

// ----- hdl/radius_neighbor_pair_finder.sv -----
// An item that scans N stored particles reads them one memory read per cycle,
// pausing while a found pair waits on a stalled output word; the compares then
// drain and its position is stored. The block takes one item at a time and holds
// in_stall until it is done. A full store instead gives a single overflow word.
// Reset clears the particle count and the output valid and sets the radius
// to 1.0; the position memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Radius neighbor pair finder
// For a non-negative radius, compares each new particle with every stored one and
// emits the index pairs whose squared distance is within the squared radius.
// ----------------------------------------------------------------------------
module radius_neighbor_pair_finder
    import rnpf_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic signed [COORD_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      start_of_set,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [IDX_W-1:0]          earlier_index,
    output logic [IDX_W-1:0]          new_index,
    output logic                      overflow,
    output logic                      last_of_run
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    logic [POS_W-1:0] mem [MAX_PARTICLES];
    logic [POS_W-1:0] mem_q;
    logic             mem_re;
    logic             mem_we;

    state_t state_reg, state_next;
    logic signed [COORD_W-1:0] radius_reg, radius_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     scan_idx_reg, scan_idx_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s2_valid_reg, s2_valid_next;
    logic              pending_valid_reg, pending_valid_next;
    logic              out_valid_reg, out_valid_next;

    logic [AW-1:0]     s1_idx_reg, s1_idx_next;
    logic [AW-1:0]     s2_idx_reg, s2_idx_next;
    logic [AW-1:0]     pending_idx_reg, pending_idx_next;
    logic [SQ_W-1:0]   sqx_reg, sqx_next;
    logic [SQ_W-1:0]   sqy_reg, sqy_next;
    logic [SQ_W-1:0]   sqz_reg, sqz_next;
    logic [R2_W-1:0]   r2_reg, r2_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  earlier_reg, earlier_next;
    logic [IDX_W-1:0]  new_index_reg, new_index_next;
    logic              overflow_reg, overflow_next;
    logic              last_reg, last_next;

    logic                      out_free;
    logic                      advance;
    logic                      s2_hit;
    logic [DIST_W-1:0]         dist_sq;
    logic [CW-1:0]             eff_count;
    logic [COORD_W-2:0]        rad_mag;
    logic signed [DIFF_W-1:0]  dx, dy, dz;
    logic signed [2*DIFF_W-1:0] px2, py2, pz2;

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign earlier_index = earlier_reg;
    assign new_index     = new_index_reg;
    assign overflow      = overflow_reg;
    assign last_of_run   = last_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign dist_sq   = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    assign s2_hit    = s2_valid_reg && (dist_sq <= DIST_W'(r2_reg));
    assign advance   = !(s2_hit && pending_valid_reg && !out_free);
    assign eff_count = start_of_set ? '0 : count_reg;
    assign rad_mag   = radius_reg[COORD_W-2:0];

    assign dx  = $signed({pos_reg[COORD_W-1], pos_reg[COORD_W-1:0]})
               - $signed({mem_q[COORD_W-1], mem_q[COORD_W-1:0]});
    assign dy  = $signed({pos_reg[2*COORD_W-1], pos_reg[2*COORD_W-1:COORD_W]})
               - $signed({mem_q[2*COORD_W-1], mem_q[2*COORD_W-1:COORD_W]});
    assign dz  = $signed({pos_reg[3*COORD_W-1], pos_reg[3*COORD_W-1:2*COORD_W]})
               - $signed({mem_q[3*COORD_W-1], mem_q[3*COORD_W-1:2*COORD_W]});
    assign px2 = dx * dx;
    assign py2 = dy * dy;
    assign pz2 = dz * dz;

    always_comb
    begin
        state_next         = state_reg;
        radius_next        = radius_reg;
        count_next         = count_reg;
        scan_idx_next      = scan_idx_reg;
        s1_valid_next      = s1_valid_reg;
        s2_valid_next      = s2_valid_reg;
        pending_valid_next = pending_valid_reg;
        out_valid_next     = out_valid_reg;
        s1_idx_next        = s1_idx_reg;
        s2_idx_next        = s2_idx_reg;
        pending_idx_next   = pending_idx_reg;
        sqx_next           = sqx_reg;
        sqy_next           = sqy_reg;
        sqz_next           = sqz_reg;
        r2_next            = r2_reg;
        pos_next           = pos_reg;
        earlier_next       = earlier_reg;
        new_index_next     = new_index_reg;
        overflow_next      = overflow_reg;
        last_next          = last_reg;
        mem_re             = 1'b0;
        mem_we             = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            radius_next = cfg_wr_data;
        end

        if (advance)
        begin
            mem_re        = (state_reg == S_SCAN);
            s1_valid_next = (state_reg == S_SCAN);
            s1_idx_next   = scan_idx_reg;
            s2_valid_next = s1_valid_reg;
            s2_idx_next   = s1_idx_reg;
            sqx_next      = px2[SQ_W-1:0];
            sqy_next      = py2[SQ_W-1:0];
            sqz_next      = pz2[SQ_W-1:0];
            if (s2_hit)
            begin
                if (pending_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    earlier_next   = IDX_W'(pending_idx_reg);
                    new_index_next = IDX_W'(count_reg);
                    overflow_next  = 1'b0;
                    last_next      = 1'b0;
                end
                pending_valid_next = 1'b1;
                pending_idx_next   = s2_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next      = {pos_z, pos_y, pos_x};
                    r2_next       = R2_W'(rad_mag * rad_mag);
                    count_next    = eff_count;
                    scan_idx_next = '0;
                    if (eff_count >= CW'(MAX_PARTICLES))
                    begin
                        state_next = S_OVF;
                    end
                    else if (radius_reg[COORD_W-1] || eff_count == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                    if (CW'(scan_idx_reg) == count_reg - CW'(1))
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!pending_valid_reg || out_free)
                begin
                    if (pending_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        earlier_next   = IDX_W'(pending_idx_reg);
                        new_index_next = IDX_W'(count_reg);
                        overflow_next  = 1'b0;
                        last_next      = 1'b1;
                    end
                    pending_valid_next = 1'b0;
                    mem_we             = 1'b1;
                    count_next         = count_reg + CW'(1);
                    state_next         = S_IDLE;
                end
            end
            S_OVF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    earlier_next   = '0;
                    new_index_next = '0;
                    overflow_next  = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            radius_reg        <= 16'sd256;
            count_reg         <= '0;
            scan_idx_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            pending_valid_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            radius_reg        <= radius_next;
            count_reg         <= count_next;
            scan_idx_reg      <= scan_idx_next;
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
            pending_valid_reg <= pending_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg      <= s1_idx_next;
        s2_idx_reg      <= s2_idx_next;
        pending_idx_reg <= pending_idx_next;
        sqx_reg         <= sqx_next;
        sqy_reg         <= sqy_next;
        sqz_reg         <= sqz_next;
        r2_reg          <= r2_next;
        pos_reg         <= pos_next;
        earlier_reg     <= earlier_next;
        new_index_reg   <= new_index_next;
        overflow_reg    <= overflow_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= pos_reg;
        end
        if (mem_re)
        begin
            mem_q <= mem[scan_idx_reg];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PARTICLES))
        else $error("particle count exceeds capacity");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!s1_valid_reg && !s2_valid_reg && !pending_valid_reg))
        else $error("compare pipeline busy while accepting a word");

    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("compare stage active outside the scan");

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (!s1_valid_reg && !s2_valid_reg && count_reg < CW'(MAX_PARTICLES)))
        else $error("position written during a scan or beyond capacity");
`endif

endmodule

// ----- verif/radius_neighbor_pair_finder_test.sv -----
// ----------------------------------------------------------------------------
// Radius neighbor pair finder testbench
// Drives particle positions through the input channel, predicts every
// (earlier, new) index pair and overflow word from its own copy of the
// particle store, and checks each output word against the oldest prediction.
// The run steps through several radius settings and idle patterns, including
// zero and negative radii and a full store.
// ----------------------------------------------------------------------------
module radius_neighbor_pair_finder_test;
    import rnpf_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic                      start;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      wait_drain;
    } particle_t;

    typedef struct {
        logic [IDX_W-1:0] earlier;
        logic [IDX_W-1:0] newer;
        logic             ovf;
        logic             last;
    } pair_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_wr_en    = 1'b0;
    logic signed [COORD_W-1:0] cfg_wr_data  = '0;
    logic                      in_valid     = 1'b0;
    logic                      start_of_set = 1'b0;
    logic signed [COORD_W-1:0] pos_x        = '0;
    logic signed [COORD_W-1:0] pos_y        = '0;
    logic signed [COORD_W-1:0] pos_z        = '0;
    logic                      out_stall    = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic [IDX_W-1:0]          earlier_index;
    logic [IDX_W-1:0]          new_index;
    logic                      overflow;
    logic                      last_of_run;

    particle_t                 particle_queue[$];
    pair_t                     pending_pairs[$];
    particle_t                 cur_particle;
    logic signed [COORD_W-1:0] store_x[CAPACITY];
    logic signed [COORD_W-1:0] store_y[CAPACITY];
    logic signed [COORD_W-1:0] store_z[CAPACITY];
    int unsigned               stored_n   = 0;
    logic signed [COORD_W-1:0] radius_now = 16'sd256;
    idle_mode_t                mode       = IDLE_NONE;
    int                        errors     = 0;
    int                        quiet      = 0;

    radius_neighbor_pair_finder #(
        .MAX_PARTICLES(CAPACITY)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_of_set (start_of_set),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .earlier_index(earlier_index),
        .new_index    (new_index),
        .overflow     (overflow),
        .last_of_run  (last_of_run)
    );

    always #4 clk = ~clk;

    function automatic void find_pairs(particle_t p);
        pair_t                     hit;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic [DIST_W-1:0]         d2;
        logic [R2_W-1:0]           r2;
        bit                        found;
        found = 1'b0;
        if (p.start)
        begin
            stored_n = 0;
        end
        if (stored_n >= CAPACITY)
        begin
            hit.earlier = '0;
            hit.newer   = '0;
            hit.ovf     = 1'b1;
            hit.last    = 1'b1;
            pending_pairs.insert(pending_pairs.size(), hit);
            return;
        end
        if (radius_now >= 0)
        begin
            r2 = radius_now * radius_now;
            for (int i = 0; i < stored_n; i++)
            begin
                dx = p.x - store_x[i];
                dy = p.y - store_y[i];
                dz = p.z - store_z[i];
                d2 = dx * dx + dy * dy + dz * dz;
                if (d2 <= DIST_W'(r2))
                begin
                    hit.earlier = IDX_W'(i);
                    hit.newer   = IDX_W'(stored_n);
                    hit.ovf     = 1'b0;
                    hit.last    = 1'b0;
                    pending_pairs.insert(pending_pairs.size(), hit);
                    found = 1'b1;
                end
            end
            if (found)
            begin
                pending_pairs[pending_pairs.size() - 1].last = 1'b1;
            end
        end
        store_x[stored_n] = p.x;
        store_y[stored_n] = p.y;
        store_z[stored_n] = p.z;
        stored_n++;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        bit gap;
        gap = $urandom_range(99) < ((mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 33 : 0);
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                find_pairs(cur_particle);
            end
            if (!in_valid || !in_stall)
            begin
                if (particle_queue.size() > 0 && !gap &&
                    !(particle_queue[0].wait_drain && pending_pairs.size() != 0))
                begin
                    cur_particle = particle_queue.pop_front();
                    in_valid     <= 1'b1;
                    start_of_set <= cur_particle.start;
                    pos_x        <= cur_particle.x;
                    pos_y        <= cur_particle.y;
                    pos_z        <= cur_particle.z;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        pair_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d",
                             $time, earlier_index, new_index, overflow, last_of_run);
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    check_field("earlier_index", 32'(want.earlier), 32'(earlier_index));
                    check_field("new_index", 32'(want.newer), 32'(new_index));
                    check_field("overflow", 32'(want.ovf), 32'(overflow));
                    check_field("last_of_run", 32'(want.last), 32'(last_of_run));
                end
            end
            out_stall <= $urandom_range(99) <
                         ((mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 33 : 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic int jitter(int spread);
        return int'($urandom_range(2 * spread)) - spread;
    endfunction

    task automatic add_particle(bit start, logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z, bit hold);
        particle_t p;
        p.start      = start;
        p.x          = x;
        p.y          = y;
        p.z          = z;
        p.wait_drain = hold;
        particle_queue.insert(particle_queue.size(), p);
    endtask

    task automatic gen_set(int count, int spread, int noise_pct, bit hold_first);
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        cx = COORD_W'($urandom);
        cy = COORD_W'($urandom);
        cz = COORD_W'($urandom);
        for (int k = 0; k < count; k++)
        begin
            if (k > 0 && $urandom_range(99) < noise_pct)
            begin
                add_particle(1'($urandom_range(1)), COORD_W'($urandom),
                             COORD_W'($urandom), COORD_W'($urandom), 1'b0);
            end
            else
            begin
                add_particle(k == 0, COORD_W'(int'(cx) + jitter(spread)),
                             COORD_W'(int'(cy) + jitter(spread)),
                             COORD_W'(int'(cz) + jitter(spread)), hold_first && k == 0);
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (particle_queue.size() != 0 || in_valid || pending_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic begin_phase(idle_mode_t m, logic signed [COORD_W-1:0] radius);
        settle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= radius;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        radius_now  = radius;
        mode        = m;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_particle(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd256, 16'sd0, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd0, 16'sd257, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd181, 16'sd181, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd128, -16'sd128, 16'sd128, 1'b0);
        add_particle(1'b1, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        add_particle(1'b0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        add_particle(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        add_particle(1'b0, -16'sd32768, -16'sd32512, -16'sd32768, 1'b0);
        add_particle(1'b0, 16'sd32767, 16'sd32767, 16'sd32511, 1'b0);
        add_particle(1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        add_particle(1'b0, 16'sh5555, -16'sh5556, 16'sh5555, 1'b0);
        add_particle(1'b0, -16'sh5556, 16'sh5555, -16'sh5556, 1'b0);
        add_particle(1'b1, -16'sd1, 16'sd1, -16'sd256, 1'b0);
        add_particle(1'b0, -16'sd1, 16'sd1, -16'sd256, 1'b0);
        add_particle(1'b0, 16'sd0, 16'sd1, -16'sd256, 1'b0);

        begin_phase(IDLE_SENDER, 16'sd0);
        gen_set(6, 0, 0, 1'b0);
        gen_set(8, 1, 0, 1'b0);
        gen_set(6, 1, 10, 1'b0);

        begin_phase(IDLE_BOTH, 16'sd32767);
        gen_set(67, 9000, 0, 1'b0);
        add_particle(1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_particle(1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        add_particle(1'b0, 16'sd1000, 16'sd1000, 16'sd1000, 1'b0);

        begin_phase(IDLE_RECEIVER, -16'sd1);
        gen_set(6, 100, 10, 1'b0);
        gen_set(6, 0, 0, 1'b0);

        begin_phase(IDLE_BOTH, COORD_W'($urandom_range(200, 3000)));
        repeat (4) gen_set($urandom_range(2, 10), 600, 8, 1'b1);

        begin_phase(IDLE_NONE, -16'sd32768);
        gen_set(10, 0, 10, 1'b0);

        begin_phase(IDLE_SENDER, COORD_W'($urandom));
        repeat (4) gen_set($urandom_range(3, 8), $urandom_range(0, 20000), 8, 1'b0);

        begin_phase(IDLE_RECEIVER, 16'sd256);
        repeat (2) gen_set(8, 200, 8, 1'b0);

        settle();
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
